/* rtl/u8rs_pkg.sv */
// ----------------------------------------------------------------------------
// u8rs_pkg
// Shared types and constants for the reverse UTF-8 code point segmenter.
// ----------------------------------------------------------------------------
package u8rs_pkg;

  localparam int UNIT_W  = 8;
  localparam int COUNT_W = 3;
  localparam int SEEN_W  = 3;
  localparam int NTRAIL  = 3;

  localparam logic [SEEN_W-1:0] TRAIL_SAT = SEEN_W'(4);

  // replacement character U+FFFD
  localparam logic [UNIT_W-1:0] REPL_U0 = 8'hEF;
  localparam logic [UNIT_W-1:0] REPL_U1 = 8'hBF;
  localparam logic [UNIT_W-1:0] REPL_U2 = 8'hBD;
  localparam logic [COUNT_W-1:0] REPL_COUNT = COUNT_W'(3);

  // Results caused by one input byte: an optional replacement, then an
  // optional code point.
  typedef struct packed {
    logic                          has_repl;
    logic                          has_cp;
    logic [3:0][UNIT_W-1:0]        cp_units;  // [0] is the lead byte
    logic [COUNT_W-1:0]            cp_count;
    logic                          done;      // byte was at string start
  } res_entry_t;

endpackage

/* rtl/u8rs_decode.sv */
// ----------------------------------------------------------------------------
// u8rs_decode
// Input register, trail byte tracking and lead byte classification.
// ----------------------------------------------------------------------------
module u8rs_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u8rs_pkg::UNIT_W-1:0]   in_code_unit,
  input  logic                          in_at_string_start,
  output logic                          push_valid,
  input  logic                          push_ready,
  output u8rs_pkg::res_entry_t          push_entry
);
  import u8rs_pkg::*;

  logic                stg_v_r;
  logic [UNIT_W-1:0]   stg_byte_r;
  logic                stg_start_r;

  logic [SEEN_W-1:0]   trail_seen_r, trail_seen_nxt;
  logic [UNIT_W-1:0]   trail_r [NTRAIL];

  logic                is_trail;
  logic                lead_bad;
  logic [1:0]          lead_len;
  logic [SEEN_W-1:0]   lead_len_w;
  logic                short_run;
  logic                excess_run;
  logic                has_result;
  logic                commit;
  res_entry_t          entry;

  always_comb begin
    is_trail = (stg_byte_r[7:6] == 2'b10);
    lead_bad = 1'b0;
    lead_len = 2'd0;
    priority if (stg_byte_r[7] == 1'b0) begin
      lead_len = 2'd0;
    end else if (stg_byte_r[7:5] == 3'b110) begin
      lead_len = 2'd1;
    end else if (stg_byte_r[7:4] == 4'b1110) begin
      lead_len = 2'd2;
    end else if (stg_byte_r[7:3] == 5'b11110) begin
      lead_len = 2'd3;
    end else begin
      lead_bad = 1'b1;
    end
    lead_len_w = SEEN_W'(lead_len);
    short_run  = trail_seen_r < lead_len_w;
    excess_run = trail_seen_r > lead_len_w;

    entry.done     = stg_start_r;
    entry.cp_count = COUNT_W'(lead_len) + COUNT_W'(1);
    entry.cp_units[0] = stg_byte_r;
    entry.cp_units[1] = (lead_len >= 2'd1) ? trail_r[0] : '0;
    entry.cp_units[2] = (lead_len >= 2'd2) ? trail_r[1] : '0;
    entry.cp_units[3] = (lead_len == 2'd3) ? trail_r[2] : '0;
    if (is_trail) begin
      entry.has_repl = stg_start_r;
      entry.has_cp   = 1'b0;
    end else begin
      entry.has_repl = lead_bad || short_run || excess_run;
      entry.has_cp   = !lead_bad && !short_run;
    end
  end

  assign has_result = entry.has_repl || entry.has_cp;
  assign commit     = stg_v_r && (push_ready || !has_result);
  assign push_valid = stg_v_r && has_result;
  assign push_entry = entry;
  assign in_ready   = !stg_v_r || commit;

  always_comb begin
    trail_seen_nxt = trail_seen_r;
    if (commit) begin
      if (stg_start_r || !is_trail) begin
        trail_seen_nxt = '0;
      end else if (trail_seen_r < TRAIL_SAT) begin
        trail_seen_nxt = trail_seen_r + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r      <= 1'b0;
      trail_seen_r <= '0;
    end else begin
      trail_seen_r <= trail_seen_nxt;
      if (in_ready) begin
        stg_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r  <= in_code_unit;
      stg_start_r <= in_at_string_start;
    end
    // newest trail byte sits nearest the lead
    if (commit && is_trail) begin
      trail_r[2] <= trail_r[1];
      trail_r[1] <= trail_r[0];
      trail_r[0] <= stg_byte_r;
    end
  end

endmodule

/* rtl/u8rs_result_queue.sv */
// ----------------------------------------------------------------------------
// u8rs_result_queue
// Two-entry queue of per-byte result pairs, unpacked onto the result port.
// ----------------------------------------------------------------------------
module u8rs_result_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_valid,
  output logic                          push_ready,
  input  u8rs_pkg::res_entry_t          push_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit0,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit1,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit2,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit3,
  output logic [u8rs_pkg::COUNT_W-1:0]  out_unit_count,
  output logic                          out_replaced,
  output logic                          out_last_of_run,
  output logic                          out_string_done
);
  import u8rs_pkg::*;

  res_entry_t   q_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r, count_nxt;
  logic         sel_r, sel_nxt;       // 1: replacement already sent for head
  res_entry_t   head;
  logic         show_repl;
  logic         beat;
  logic         pop;
  logic         push;

  assign head      = q_r[rd_ptr_r];
  assign show_repl = head.has_repl && !sel_r;
  assign out_valid = (count_r != 2'd0);
  assign beat      = out_valid && out_ready;
  assign pop       = beat && !(show_repl && head.has_cp);
  assign push_ready = (count_r != 2'd2) || pop;
  assign push      = push_valid && push_ready;

  always_comb begin
    if (show_repl) begin
      out_unit0       = REPL_U0;
      out_unit1       = REPL_U1;
      out_unit2       = REPL_U2;
      out_unit3       = '0;
      out_unit_count  = REPL_COUNT;
      out_replaced    = 1'b1;
      out_last_of_run = !head.has_cp;
    end else begin
      out_unit0       = head.cp_units[0];
      out_unit1       = head.cp_units[1];
      out_unit2       = head.cp_units[2];
      out_unit3       = head.cp_units[3];
      out_unit_count  = head.cp_count;
      out_replaced    = 1'b0;
      out_last_of_run = 1'b1;
    end
    out_string_done = out_last_of_run && head.done;
  end

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
    sel_nxt = sel_r;
    if (beat) begin
      sel_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
      sel_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sel_r   <= sel_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/utf8_reverse_code_point_segmenter.sv */
// ----------------------------------------------------------------------------
// utf8_reverse_code_point_segmenter
// Splits a UTF-8 string fed last byte first into code points, replacing
// malformed runs with U+FFFD.
//
//   channel | ports                                   | direction
//   in      | in_valid/in_ready, in_code_unit,        | sink
//           | in_at_string_start                      |
//   out     | out_valid/out_ready, out_unit0..3,      | source
//           | out_unit_count, out_replaced,           |
//           | out_last_of_run, out_string_done        |
//
// One byte accepted per cycle while the result queue has room. A byte waits in
// the input register, then its results enter a two-entry queue that drives the
// result port. A byte that causes a replacement and a code point holds the
// result port for two beats, the replacement first. Reset clears the trail
// count and queue. Output stalls back up through the queue into in_ready.
// ----------------------------------------------------------------------------
module utf8_reverse_code_point_segmenter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u8rs_pkg::UNIT_W-1:0]   in_code_unit,
  input  logic                          in_at_string_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit0,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit1,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit2,
  output logic [u8rs_pkg::UNIT_W-1:0]   out_unit3,
  output logic [u8rs_pkg::COUNT_W-1:0]  out_unit_count,
  output logic                          out_replaced,
  output logic                          out_last_of_run,
  output logic                          out_string_done
);
  import u8rs_pkg::*;

  logic       push_valid;
  logic       push_ready;
  res_entry_t push_entry;

  u8rs_decode u_decode (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_code_unit       (in_code_unit),
    .in_at_string_start (in_at_string_start),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_entry         (push_entry)
  );

  u8rs_result_queue u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_entry      (push_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_unit0       (out_unit0),
    .out_unit1       (out_unit1),
    .out_unit2       (out_unit2),
    .out_unit3       (out_unit3),
    .out_unit_count  (out_unit_count),
    .out_replaced    (out_replaced),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done)
  );

endmodule

/* tb/utf8_reverse_code_point_segmenter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_reverse_code_point_segmenter_tb
// Feeds UTF-8 strings last byte first, well formed and damaged, plus raw
// noise, through the segmenter under several idle/stall patterns and checks
// every emitted result against a cycle-free prediction or a typed expectation.
// ----------------------------------------------------------------------------
module utf8_reverse_code_point_segmenter_tb;
  import u8rs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_TAIL     = 8;
  localparam int HOLD_CYCLES    = 250;
  localparam int SEG_ITEMS      = 100;
  localparam int NUM_SEGS       = 8;
  localparam int NDIR           = 27;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [UNIT_W-1:0]  unit0;
    logic [UNIT_W-1:0]  unit1;
    logic [UNIT_W-1:0]  unit2;
    logic [UNIT_W-1:0]  unit3;
    logic [COUNT_W-1:0] unit_count;
    logic               replaced;
    logic               last_of_run;
    logic               string_done;
  } cp_res_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              start;
    logic              typed;
    cp_res_t           want;
  } stim_row_t;

  localparam cp_res_t NO_EXP    = '0;
  localparam cp_res_t REPL_LAST = {REPL_U0, REPL_U1, REPL_U2, 8'h00, REPL_COUNT, 3'b110};
  localparam cp_res_t REPL_DONE = {REPL_U0, REPL_U1, REPL_U2, 8'h00, REPL_COUNT, 3'b111};

  // directed rows: typed expectation only where it is obvious
  localparam stim_row_t DIR_ROWS [NDIR] = '{
    {8'h41, 1'b1, 1'b1, 8'h41, 24'h0, 3'd1, 3'b011},
    {8'h00, 1'b1, 1'b1, 8'h00, 24'h0, 3'd1, 3'b011},
    {8'h7F, 1'b0, 1'b1, 8'h7F, 24'h0, 3'd1, 3'b010},
    {8'hFF, 1'b1, 1'b1, REPL_DONE},
    {8'hF8, 1'b0, 1'b1, REPL_LAST},
    {8'h80, 1'b1, 1'b1, REPL_DONE},   // lone trail at string start
    {8'hBF, 1'b1, 1'b1, REPL_DONE},
    {8'hA9, 1'b0, 1'b0, NO_EXP},
    {8'hC3, 1'b0, 1'b0, NO_EXP},
    {8'hAC, 1'b0, 1'b0, NO_EXP},
    {8'h82, 1'b0, 1'b0, NO_EXP},
    {8'hE2, 1'b0, 1'b0, NO_EXP},
    {8'h80, 1'b0, 1'b0, NO_EXP},
    {8'h98, 1'b0, 1'b0, NO_EXP},
    {8'h9F, 1'b0, 1'b0, NO_EXP},
    {8'hF0, 1'b0, 1'b0, NO_EXP},
    {8'hBF, 1'b0, 1'b0, NO_EXP},
    {8'hEF, 1'b0, 1'b1, REPL_LAST},   // too few trails
    {8'h80, 1'b0, 1'b0, NO_EXP},
    {8'h81, 1'b0, 1'b0, NO_EXP},
    {8'h82, 1'b0, 1'b0, NO_EXP},
    {8'h83, 1'b0, 1'b0, NO_EXP},
    {8'h84, 1'b0, 1'b0, NO_EXP},      // count saturates
    {8'hDF, 1'b0, 1'b0, NO_EXP},      // excess: replacement then code point
    {8'hA5, 1'b0, 1'b0, NO_EXP},
    {8'hFC, 1'b0, 1'b1, REPL_LAST},   // bad lead swallows pending trail
    {8'hC0, 1'b1, 1'b1, REPL_DONE}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [UNIT_W-1:0]    in_code_unit;
  logic                 in_at_string_start;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [UNIT_W-1:0]    out_unit0;
  logic [UNIT_W-1:0]    out_unit1;
  logic [UNIT_W-1:0]    out_unit2;
  logic [UNIT_W-1:0]    out_unit3;
  logic [COUNT_W-1:0]   out_unit_count;
  logic                 out_replaced;
  logic                 out_last_of_run;
  logic                 out_string_done;

  utf8_reverse_code_point_segmenter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_unit      (in_code_unit),
    .in_at_string_start(in_at_string_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_unit0         (out_unit0),
    .out_unit1         (out_unit1),
    .out_unit2         (out_unit2),
    .out_unit3         (out_unit3),
    .out_unit_count    (out_unit_count),
    .out_replaced      (out_replaced),
    .out_last_of_run   (out_last_of_run),
    .out_string_done   (out_string_done)
  );

  always #5 clk = ~clk;

  idle_mode_t        idle_mode = IDLE_NONE;
  int                err_count = 0;
  int                hold_reqs = 0;
  int                stuck_cycles = 0;
  int                seg_sent;
  logic              drv_typed;
  cp_res_t           drv_want;
  cp_res_t           code_points_due [$];
  logic [UNIT_W-1:0] str_bytes [$];

  // decoder state mirror
  logic [SEEN_W-1:0] trail_cnt = '0;
  logic [UNIT_W-1:0] trail_hist [NTRAIL];
  cp_res_t           seg_res [2];
  int                seg_n;

  cp_res_t           got_res;
  cp_res_t           want_res;
  int                acc_i;

  function automatic void add_result(logic [31:0] units, logic [COUNT_W-1:0] cnt,
                                     logic rep);
    int i;
    for (i = 0; i < 4; i++)
      if (i >= cnt) units[31-8*i -: 8] = 8'h00;
    seg_res[seg_n] = {units, cnt, rep, 2'b00};
    seg_n++;
  endfunction

  function automatic void segment_byte(logic [UNIT_W-1:0] b, logic st);
    int t;
    seg_n = 0;
    if (b >= 8'h80 && b < 8'hC0) begin
      trail_hist[2] = trail_hist[1];
      trail_hist[1] = trail_hist[0];
      trail_hist[0] = b;
      if (trail_cnt < TRAIL_SAT) trail_cnt++;
      if (st) add_result({REPL_U0, REPL_U1, REPL_U2, 8'h00}, REPL_COUNT, 1'b1);
    end else begin
      if (b < 8'h80)      t = 0;
      else if (b < 8'hE0) t = 1;
      else if (b < 8'hF0) t = 2;
      else if (b < 8'hF8) t = 3;
      else                t = -1;
      if (t < 0 || int'(trail_cnt) < t) begin
        add_result({REPL_U0, REPL_U1, REPL_U2, 8'h00}, REPL_COUNT, 1'b1);
      end else begin
        if (int'(trail_cnt) > t)
          add_result({REPL_U0, REPL_U1, REPL_U2, 8'h00}, REPL_COUNT, 1'b1);
        add_result({b, trail_hist[0], trail_hist[1], trail_hist[2]},
                   COUNT_W'(t + 1), 1'b0);
      end
      trail_cnt = '0;
    end
    if (seg_n > 0) begin
      seg_res[seg_n-1].last_of_run = 1'b1;
      if (st) begin
        seg_res[seg_n-1].string_done = 1'b1;
        trail_cnt = '0;
        trail_hist = '{default: '0};
      end
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      err_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, e, a);
    end
  endfunction

  // accept beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        segment_byte(in_code_unit, in_at_string_start);
        if (drv_typed)
          code_points_due.push_back(drv_want);
        else
          for (acc_i = 0; acc_i < seg_n; acc_i++)
            code_points_due.push_back(seg_res[acc_i]);
      end
      if (out_valid && out_ready) begin
        got_res = {out_unit0, out_unit1, out_unit2, out_unit3, out_unit_count,
                   out_replaced, out_last_of_run, out_string_done};
        if (code_points_due.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, got %h", $time, got_res);
        end else begin
          want_res = code_points_due.pop_front();
          check_field("unit0", want_res.unit0, got_res.unit0);
          check_field("unit1", want_res.unit1, got_res.unit1);
          check_field("unit2", want_res.unit2, got_res.unit2);
          check_field("unit3", want_res.unit3, got_res.unit3);
          check_field("unit_count", UNIT_W'(want_res.unit_count),
                      UNIT_W'(got_res.unit_count));
          check_field("replaced", UNIT_W'(want_res.replaced),
                      UNIT_W'(got_res.replaced));
          check_field("last_of_run", UNIT_W'(want_res.last_of_run),
                      UNIT_W'(got_res.last_of_run));
          check_field("string_done", UNIT_W'(want_res.string_done),
                      UNIT_W'(got_res.string_done));
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  int hold_left = 0;
  int hold_taken = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_taken) begin
      hold_taken = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_ready <= ($urandom_range(99) >= 55);
        IDLE_BOTH: out_ready <= ($urandom_range(99) >= 8);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(logic [UNIT_W-1:0] b, logic st, logic typed, cp_res_t want);
    int pct;
    int gap;
    pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    gap = ($urandom_range(99) < pct) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_code_unit       <= b;
    in_at_string_start <= st;
    drv_typed          <= typed;
    drv_want           <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    seg_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (code_points_due.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic push_code_point(int len, int ntrail);
    case (len)
      1:       str_bytes.push_back(UNIT_W'($urandom_range(8'h7F, 8'h00)));
      2:       str_bytes.push_back(UNIT_W'($urandom_range(8'hDF, 8'hC0)));
      3:       str_bytes.push_back(UNIT_W'($urandom_range(8'hEF, 8'hE0)));
      default: str_bytes.push_back(UNIT_W'($urandom_range(8'hF7, 8'hF0)));
    endcase
    repeat (ntrail) str_bytes.push_back(UNIT_W'($urandom_range(8'hBF, 8'h80)));
  endtask

  // forward-order string, mostly well formed
  task automatic compose_string();
    int n_cp;
    int kind;
    int len;
    str_bytes.delete();
    n_cp = $urandom_range(6, 1);
    repeat (n_cp) begin
      kind = $urandom_range(99);
      len  = $urandom_range(4, 1);
      if (kind < 70) begin
        push_code_point(len, len - 1);
      end else if (kind < 78) begin
        len = $urandom_range(4, 2);
        push_code_point(len, $urandom_range(len - 2, 0));
      end else if (kind < 86) begin
        push_code_point(len, len - 1 + $urandom_range(6, 1));
      end else if (kind < 92) begin
        str_bytes.push_back(UNIT_W'($urandom_range(8'hFF, 8'hF8)));
        repeat ($urandom_range(3, 0))
          str_bytes.push_back(UNIT_W'($urandom_range(8'hBF, 8'h80)));
      end else begin
        repeat ($urandom_range(3, 1))
          str_bytes.push_back(UNIT_W'($urandom_range(8'hBF, 8'h80)));
      end
    end
  endtask

  int row;
  int seg;
  int bi;
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_code_unit       = '0;
    in_at_string_start = 1'b0;
    drv_typed          = 1'b0;
    drv_want           = NO_EXP;
    trail_hist         = '{default: '0};
    seg_sent           = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < NDIR; row++)
      send_byte(DIR_ROWS[row].unit, DIR_ROWS[row].start, DIR_ROWS[row].typed,
                DIR_ROWS[row].want);
    wait_drained();

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      idle_mode = idle_mode_t'(seg % 4);
      if (seg == 4) hold_reqs++;   // receiver backs off, input should stall
      seg_sent = 0;
      while (seg_sent < SEG_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(8, 1))
            send_byte(UNIT_W'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, NO_EXP);
        end else begin
          compose_string();
          for (bi = str_bytes.size() - 1; bi >= 0; bi--)
            send_byte(str_bytes[bi], bi == 0, 1'b0, NO_EXP);
        end
      end
      wait_drained();
    end

    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
